// File: design/uart_line_coding_baud_divider_assert.svh
// Assertion macros for the UART line coding baud divider.
// Expects signals named clk and arst_n in the including module.
`ifndef UART_LINE_CODING_BAUD_DIVIDER_ASSERT_SVH
`define UART_LINE_CODING_BAUD_DIVIDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ULCBD_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ULCBD_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ulcbd_pkg.sv
// Shared constants and types for the UART line coding baud divider.
// No dependencies; used by ulcbd_div and uart_line_coding_baud_divider.
package ulcbd_pkg;

	localparam int ClkW   = 27;          // configured clock width
	localparam int CW     = ClkW - 4;    // clock / 16
	localparam int BaudW  = 22;          // applied baud width
	localparam int QuoW   = 18;          // widest quotient c / baud
	localparam int DivOutW = 16;         // divisor field width

	localparam logic [31:0]      BaudMin   = 32'd46;
	localparam logic [31:0]      BaudMax   = 32'd3000000;
	localparam logic [ClkW-1:0]  ClkReset  = 27'd48000000;
	localparam logic [BaudW-1:0] BaudReset = 22'd9600;
	localparam logic [3:0]       DataReset = 4'd8;
	localparam logic [3:0]       FracSteps = 4'd15;
	localparam logic [3:0]       FracLast  = 4'd14;
	localparam logic [3:0]       MulInt    = 4'd1;
	localparam logic [1:0]       StopOne   = 2'd0;
	localparam logic [1:0]       StopTwo   = 2'd2;
	localparam logic [1:0]       ParFieldMask = 2'h3;
	localparam logic [4:0]       SearchLim = 5'd30;  // search runs when r < 30

	// floor(x / 15) = (x * Recip15) >> Recip15Sh for any x below 2**22
	localparam logic [22:0]      Recip15   = 23'd4473925;
	localparam int               Recip15Sh = 26;

	// request into the divider
	typedef struct packed {
		logic             start;
		logic [CW-1:0]    dividend;
		logic [BaudW-1:0] divisor;
	} div_req_t;

	// answer from the divider
	typedef struct packed {
		logic             done;
		logic [CW-1:0]    quotient;
		logic [BaudW-1:0] remainder;
	} div_rsp_t;

endpackage

// File: design/ulcbd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, used by the sequencer.
// Depends on ulcbd_pkg for widths and the request/answer structs.
module ulcbd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ulcbd_pkg::div_req_t req,
	output ulcbd_pkg::div_rsp_t rsp
);

	localparam int CW    = ulcbd_pkg::CW;
	localparam int BW    = ulcbd_pkg::BaudW;
	localparam int CntW  = $clog2(CW + 1);
	localparam logic [CntW-1:0] Steps = CntW'(CW);

	logic [CW-1:0]   quo_q;
	logic [BW-1:0]   rem_q;
	logic [BW-1:0]   dsr_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [BW:0] part;
	logic [BW:0] diff;
	logic        fits;

	// one trial subtraction per cycle
	always_comb begin
		part = {rem_q, quo_q[CW-1]};
		diff = part - {1'b0, dsr_q};
		fits = part >= {1'b0, dsr_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= Steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[CW-2:0], fits};
			rem_q <= fits ? diff[BW-1:0] : part[BW-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: design/uart_line_coding_baud_divider.sv
// UART line coding check and fractional baud divider search, top level.
// Depends on ulcbd_pkg, ulcbd_div and uart_line_coding_baud_divider_assert.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | req_baud, req_data_bits, req_parity, ...
//  out     | out_valid / out_stall| divisor, divisor_clipped, frac_*, applied_*
//  cfg     | cfg_wr_en            | cfg_wr_data (uart clock in Hz)
//
// Without a search an item runs the divide, then the round-up check and the result.
// With a search (c/baud below 30) baud/15 is formed by reciprocal multiply, t is
// stepped up to divisor r/2, and each divisor from r/2 to r tries 15 fractions.
// The radix-2 divider and the one-candidate-per-cycle error compare set the run time.
// Reset loads 48 MHz, 9600 baud, 8 data bits, no parity, one stop bit.
// in_stall is high while an item is in work; a stalled result holds the output.
module uart_line_coding_baud_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [26:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] req_baud,
	input  logic [7:0]  req_data_bits,
	input  logic [7:0]  req_parity,
	input  logic [7:0]  req_stop_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] divisor,
	output logic        divisor_clipped,
	output logic [3:0]  frac_add,
	output logic [3:0]  frac_mul,
	output logic [6:0]  line_control,
	output logic [21:0] applied_baud,
	output logic [3:0]  applied_data_bits,
	output logic [7:0]  applied_parity,
	output logic [1:0]  applied_stop_bits
);

	localparam int CW  = ulcbd_pkg::CW;
	localparam int BW  = ulcbd_pkg::BaudW;
	localparam int QW  = ulcbd_pkg::QuoW;
	localparam int PW  = BW + 23;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StDiv1 = 3'd1;
	localparam logic [2:0] StDiv2 = 3'd2;
	localparam logic [2:0] StAdv  = 3'd3;
	localparam logic [2:0] StSrch = 3'd4;
	localparam logic [2:0] StChk1 = 3'd5;
	localparam logic [2:0] StChk2 = 3'd6;
	localparam logic [2:0] StDone = 3'd7;

	// control and held line coding
	logic [2:0]             state_q;
	logic                   out_valid_q;
	logic [ulcbd_pkg::ClkW-1:0] clk_hz_q;
	logic [BW-1:0]          held_baud_q;
	logic [3:0]             held_data_q;
	logic [7:0]             held_par_q;
	logic [1:0]             held_stop_q;

	// datapath
	logic [QW-1:0]  r_q;
	logic [QW-1:0]  div_q;
	logic [3:0]     fadd_q;
	logic [3:0]     fmul_q;
	logic [BW-1:0]  best_q;
	logic [CW-1:0]  best_t_q;
	logic [CW-1:0]  t_q;
	logic [CW-1:0]  tf_q;
	logic [CW-1:0]  tq_q;
	logic [3:0]     tr_q;
	logic [QW-1:0]  bq_q;
	logic [3:0]     br_q;
	logic [CW-1:0]  acc_q;
	logic [3:0]     acc_r_q;
	logic [4:0]     d_q;
	logic [3:0]     a_q;
	logic [CW:0]    sum_q;

	// output register
	logic [15:0] divisor_q;
	logic        clip_q;
	logic [3:0]  fadd_out_q;
	logic [3:0]  fmul_out_q;
	logic [6:0]  lc_q;
	logic [21:0] ab_q;
	logic [3:0]  ad_q;
	logic [7:0]  ap_q;
	logic [1:0]  as_q;

	logic                accept;
	logic                load_out;
	logic [BW-1:0]       sel_baud;
	logic [3:0]          sel_data;
	logic [1:0]          sel_stop;
	logic [CW-1:0]       c;
	logic                search_go;
	ulcbd_pkg::div_req_t div_req;
	ulcbd_pkg::div_rsp_t div_rsp;

	logic [PW-1:0] q15_prod;
	logic [QW-1:0] q15;
	logic [4:0]    r_half;
	logic [CW-1:0] t_nx;
	logic [CW-1:0] tf_nx;
	logic [4:0]    tr_sum;
	logic          tr_wrap;
	logic [3:0]    tr_nx;
	logic [CW-1:0] tq_nx;
	logic [4:0]    accr_sum;
	logic          accr_wrap;
	logic [3:0]    accr_nx;
	logic [CW-1:0] acc_nx;
	logic [CW-1:0] err;
	logic          better;
	logic [CW:0]   rnd_err;
	logic [QW-1:0] div_fin;

	assign c         = clk_hz_q[ulcbd_pkg::ClkW-1:4];
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != StIdle);
	assign load_out  = (state_q == StDone) && (!out_valid_q || !out_stall);
	assign search_go = (div_rsp.quotient < CW'(ulcbd_pkg::SearchLim));
	assign r_half    = {1'b0, r_q[4:1]};

	// fallback to the held coding for out-of-range requests
	always_comb begin
		if (req_baud < ulcbd_pkg::BaudMin || req_baud > ulcbd_pkg::BaudMax)
			sel_baud = held_baud_q;
		else
			sel_baud = req_baud[BW-1:0];
		if (req_stop_bits == 8'(ulcbd_pkg::StopOne) || req_stop_bits == 8'(ulcbd_pkg::StopTwo))
			sel_stop = req_stop_bits[1:0];
		else
			sel_stop = held_stop_q;
		if (req_data_bits >= 8'd5 && req_data_bits <= 8'd8)
			sel_data = req_data_bits[3:0];
		else
			sel_data = held_data_q;
	end

	// divider request: c / baud on accept
	always_comb begin
		div_req.start    = accept;
		div_req.dividend = c;
		div_req.divisor  = sel_baud;
	end

	ulcbd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// baud / 15 by reciprocal multiply; remainder from the low bits
	always_comb begin
		q15_prod = PW'(held_baud_q) * PW'(ulcbd_pkg::Recip15);
		q15      = q15_prod[ulcbd_pkg::Recip15Sh +: QW];
	end

	// next divisor candidate: t += baud, keeping t / 15 as quotient and remainder
	always_comb begin
		t_nx    = t_q + CW'(held_baud_q);
		tf_nx   = tf_q - CW'(held_baud_q);
		tr_sum  = {1'b0, tr_q} + {1'b0, br_q};
		tr_wrap = tr_sum >= 5'(ulcbd_pkg::FracSteps);
		tr_nx   = tr_wrap ? 4'(tr_sum - 5'(ulcbd_pkg::FracSteps)) : tr_sum[3:0];
		tq_nx   = tq_q + CW'(bq_q) + CW'(tr_wrap);
	end

	// next fraction: acc = floor(t*a/15) kept incrementally
	always_comb begin
		accr_sum  = {1'b0, acc_r_q} + {1'b0, tr_q};
		accr_wrap = accr_sum >= 5'(ulcbd_pkg::FracSteps);
		accr_nx   = accr_wrap ? 4'(accr_sum - 5'(ulcbd_pkg::FracSteps)) : accr_sum[3:0];
		acc_nx    = acc_q + tq_q + CW'(accr_wrap);
	end

	// candidate error |(c - t) - floor(t*a/15)| against the best so far
	always_comb begin
		err    = (tf_q >= acc_q) ? (tf_q - acc_q) : (acc_q - tf_q);
		better = err < CW'(best_q);
	end

	// round-up check |c - baud*(d+1)|
	always_comb begin
		rnd_err = ({1'b0, c} >= sum_q) ? ({1'b0, c} - sum_q) : (sum_q - {1'b0, c});
		div_fin = div_q + 1'b1;
	end

	// sequencer, held coding and clock register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
			clk_hz_q    <= ulcbd_pkg::ClkReset;
			held_baud_q <= ulcbd_pkg::BaudReset;
			held_data_q <= ulcbd_pkg::DataReset;
			held_par_q  <= '0;
			held_stop_q <= ulcbd_pkg::StopOne;
		end else begin
			if (cfg_wr_en)
				clk_hz_q <= cfg_wr_data;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						held_baud_q <= sel_baud;
						held_data_q <= sel_data;
						held_par_q  <= req_parity;
						held_stop_q <= sel_stop;
						state_q     <= StDiv1;
					end
				end
				StDiv1: begin
					if (div_rsp.done)
						state_q <= search_go ? StDiv2 : StChk1;
				end
				StDiv2: state_q <= StAdv;
				StAdv: begin
					if (d_q == r_half)
						state_q <= StSrch;
				end
				StSrch: begin
					if (a_q == ulcbd_pkg::FracLast && d_q == r_q[4:0])
						state_q <= StChk1;
				end
				StChk1: state_q <= StChk2;
				StChk2: state_q <= StDone;
				StDone: begin
					if (load_out)
						state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			StDiv1: begin
				if (div_rsp.done) begin
					r_q      <= div_rsp.quotient[QW-1:0];
					div_q    <= div_rsp.quotient[QW-1:0];
					best_q   <= div_rsp.remainder;
					best_t_q <= c - CW'(div_rsp.remainder);
					fadd_q   <= '0;
					fmul_q   <= ulcbd_pkg::MulInt;
					t_q      <= '0;
					tf_q     <= c;
					tq_q     <= '0;
					tr_q     <= '0;
					d_q      <= '0;
				end
			end
			StDiv2: begin
				bq_q <= q15;
				br_q <= held_baud_q[3:0] + q15[3:0];
			end
			StAdv: begin
				if (d_q == r_half) begin
					a_q     <= '0;
					acc_q   <= '0;
					acc_r_q <= '0;
				end else begin
					t_q  <= t_nx;
					tf_q <= tf_nx;
					tq_q <= tq_nx;
					tr_q <= tr_nx;
					d_q  <= d_q + 1'b1;
				end
			end
			StSrch: begin
				if (better) begin
					div_q    <= QW'(d_q);
					fadd_q   <= a_q;
					fmul_q   <= ulcbd_pkg::FracSteps;
					best_q   <= err[BW-1:0];
					best_t_q <= t_q;
				end
				if (a_q == ulcbd_pkg::FracLast) begin
					a_q     <= '0;
					acc_q   <= '0;
					acc_r_q <= '0;
					if (d_q != r_q[4:0]) begin
						t_q  <= t_nx;
						tf_q <= tf_nx;
						tq_q <= tq_nx;
						tr_q <= tr_nx;
						d_q  <= d_q + 1'b1;
					end
				end else begin
					a_q     <= a_q + 1'b1;
					acc_q   <= acc_nx;
					acc_r_q <= accr_nx;
				end
			end
			StChk1: sum_q <= {1'b0, best_t_q} + (CW+1)'(held_baud_q);
			StChk2: begin
				if (rnd_err < (CW+1)'(best_q)) begin
					div_q  <= div_fin;
					fadd_q <= '0;
					fmul_q <= ulcbd_pkg::MulInt;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			clip_q       <= (div_q > QW'(16'hFFFF));
			divisor_q    <= (div_q > QW'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
			fadd_out_q   <= fadd_q;
			fmul_out_q   <= fmul_q;
			lc_q         <= {1'b0,
			                 held_par_q[1:0] - 2'd1 & ulcbd_pkg::ParFieldMask,
			                 (held_par_q != 8'd0),
			                 (held_stop_q != ulcbd_pkg::StopOne),
			                 held_data_q[1:0] - 2'd1};
			ab_q         <= held_baud_q;
			ad_q         <= held_data_q;
			ap_q         <= held_par_q;
			as_q         <= held_stop_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign divisor           = divisor_q;
	assign divisor_clipped   = clip_q;
	assign frac_add          = fadd_out_q;
	assign frac_mul          = fmul_out_q;
	assign line_control      = lc_q;
	assign applied_baud      = ab_q;
	assign applied_data_bits = ad_q;
	assign applied_parity    = ap_q;
	assign applied_stop_bits = as_q;

	// checks
	`include "uart_line_coding_baud_divider_assert.svh"

	`ULCBD_AST_IMP(a_clip_sat, out_valid_q && clip_q, divisor_q == 16'hFFFF, "clipped divisor not saturated")
	`ULCBD_AST_IMP(a_frac_pair, out_valid_q, (fmul_out_q == ulcbd_pkg::FracSteps || fadd_out_q == 4'd0) && fadd_out_q != ulcbd_pkg::FracSteps, "fraction add/mul pair inconsistent")
	`ULCBD_AST_NXT(a_start_div, in_valid && !in_stall, state_q == StDiv1, "accepted item did not start the divide")
	`ULCBD_AST_IMP(a_srch_range, state_q == StSrch, d_q <= r_q[4:0] && a_q <= ulcbd_pkg::FracLast, "search counters out of range")

endmodule

// File: tb/uart_line_coding_baud_divider_check.sv
// Checker for the UART line coding baud divider: watches the config, request and
// result channels, predicts each result from its own copy of the state, compares.
// Depends on ulcbd_pkg for reset values and limits.
module uart_line_coding_baud_divider_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [26:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] req_baud,
	input  logic [7:0]  req_data_bits,
	input  logic [7:0]  req_parity,
	input  logic [7:0]  req_stop_bits,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] divisor,
	input  logic        divisor_clipped,
	input  logic [3:0]  frac_add,
	input  logic [3:0]  frac_mul,
	input  logic [6:0]  line_control,
	input  logic [21:0] applied_baud,
	input  logic [3:0]  applied_data_bits,
	input  logic [7:0]  applied_parity,
	input  logic [1:0]  applied_stop_bits,
	output int unsigned open_items,
	output int unsigned mismatches
);

	localparam int unsigned Oversample = 16;
	localparam int unsigned NumFields  = 9;

	typedef struct packed {
		logic [15:0] divisor;
		logic        clipped;
		logic [3:0]  fadd;
		logic [3:0]  fmul;
		logic [6:0]  lc;
		logic [21:0] baud;
		logic [3:0]  data;
		logic [7:0]  parity;
		logic [1:0]  stop;
	} coding_t;

	// model copy of the clock register and the held line coding
	logic [ulcbd_pkg::ClkW-1:0]  clk_hz;
	logic [ulcbd_pkg::BaudW-1:0] held_baud;
	logic [3:0]                  held_data;
	logic [1:0]                  held_stop;

	coding_t     coding_due[$];
	int unsigned results_seen;

	string field_tag [NumFields] = '{"divisor", "divisor_clipped", "frac_add", "frac_mul",
		"line_control", "applied_baud", "applied_data_bits", "applied_parity",
		"applied_stop_bits"};

	function automatic longint unsigned abs_gap(longint unsigned x, longint unsigned y);
		return (x >= y) ? x - y : y - x;
	endfunction

	// applies fallback, updates the held coding and searches the divider setting
	function automatic coding_t predict_coding(logic [31:0] want_baud, logic [7:0] want_data,
			logic [7:0] want_parity, logic [7:0] want_stop);
		coding_t         res;
		longint unsigned baud, c, r, dv, best, t, tf, e, d;
		int unsigned     a;
		logic [3:0]      fadd, fmul;
		logic [7:0]      data, stop, dm5, pm1;
		logic            clipped;
		baud = want_baud;
		if (baud < ulcbd_pkg::BaudMin || baud > ulcbd_pkg::BaudMax)
			baud = held_baud;
		data = want_data;
		if (data < 8'd5 || data > 8'd8)
			data = held_data;
		stop = want_stop;
		if (stop != ulcbd_pkg::StopOne && stop != ulcbd_pkg::StopTwo)
			stop = held_stop;
		held_baud = baud[ulcbd_pkg::BaudW-1:0];
		held_data = data[3:0];
		held_stop = stop[1:0];

		c = clk_hz / Oversample;
		r = c / baud;
		dv = r;
		fadd = 4'd0;
		fmul = ulcbd_pkg::MulInt;
		best = c - baud * r;
		// fractional search over divisors r/2..r for small dividers
		if ((r >> 1) < ulcbd_pkg::FracSteps) begin
			for (d = r >> 1; d <= r; d++) begin
				t = d * baud;
				tf = abs_gap(c, t);
				for (a = 0; a < ulcbd_pkg::FracSteps; a++) begin
					e = abs_gap(tf, (t * a) / ulcbd_pkg::FracSteps);
					if (e < best) begin
						dv = d;
						fadd = a[3:0];
						fmul = ulcbd_pkg::FracSteps;
						best = e;
					end
				end
			end
		end
		// round up when the next divisor is closer
		if (abs_gap(c, baud * (dv + 1)) < best) begin
			dv = dv + 1;
			fadd = 4'd0;
			fmul = ulcbd_pkg::MulInt;
		end
		clipped = dv > 64'hFFFF;
		if (clipped)
			dv = 64'hFFFF;

		dm5 = data - 8'd5;
		pm1 = want_parity - 8'd1;
		res.divisor = dv[15:0];
		res.clipped = clipped;
		res.fadd = fadd;
		res.fmul = fmul;
		res.lc = {1'b0, pm1[1:0] & ulcbd_pkg::ParFieldMask, want_parity != 8'd0,
			stop != ulcbd_pkg::StopOne, dm5[1:0]};
		res.baud = baud[ulcbd_pkg::BaudW-1:0];
		res.data = data[3:0];
		res.parity = want_parity;
		res.stop = stop[1:0];
		return res;
	endfunction

	function automatic void note_fail(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// compare one result against the oldest outstanding coding
	function automatic void check_result();
		coding_t         w;
		longint unsigned want [NumFields];
		longint unsigned got [NumFields];
		int unsigned     i;
		results_seen++;
		if (coding_due.size() == 0) begin
			note_fail($sformatf("result %0d arrived with no item outstanding", results_seen));
			return;
		end
		w = coding_due.pop_front();
		want = '{w.divisor, w.clipped, w.fadd, w.fmul, w.lc, w.baud, w.data, w.parity, w.stop};
		got = '{divisor, divisor_clipped, frac_add, frac_mul, line_control, applied_baud,
			applied_data_bits, applied_parity, applied_stop_bits};
		for (i = 0; i < NumFields; i++)
			if (want[i] != got[i])
				note_fail($sformatf("result %0d %s expected %0d got %0d", results_seen,
					field_tag[i], want[i], got[i]));
	endfunction

	// config first, then results, then new items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz = ulcbd_pkg::ClkReset;
			held_baud = ulcbd_pkg::BaudReset;
			held_data = ulcbd_pkg::DataReset;
			held_stop = ulcbd_pkg::StopOne;
			coding_due.delete();
			results_seen = 0;
			open_items = 0;
			mismatches = 0;
		end else begin
			if (cfg_wr_en)
				clk_hz = cfg_wr_data;
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				coding_due.push_back(predict_coding(req_baud, req_data_bits, req_parity,
					req_stop_bits));
			open_items = coding_due.size();
		end
	end

endmodule

// File: tb/uart_line_coding_baud_divider_test.sv
// Testbench top for the UART line coding baud divider: clock, reset, stimulus,
// result-side stalls and the verdict. Depends on ulcbd_pkg, the block and the checker.
module uart_line_coding_baud_divider_test;

	localparam int unsigned ItemsPerPhase = 160;
	localparam int unsigned NumPhases     = 10;
	localparam logic [7:0]  SOne          = 8'(ulcbd_pkg::StopOne);
	localparam logic [7:0]  STwo          = 8'(ulcbd_pkg::StopTwo);

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [26:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] req_baud;
	logic [7:0]  req_data_bits;
	logic [7:0]  req_parity;
	logic [7:0]  req_stop_bits;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] divisor;
	logic        divisor_clipped;
	logic [3:0]  frac_add;
	logic [3:0]  frac_mul;
	logic [6:0]  line_control;
	logic [21:0] applied_baud;
	logic [3:0]  applied_data_bits;
	logic [7:0]  applied_parity;
	logic [1:0]  applied_stop_bits;
	int unsigned open_items;
	int unsigned mismatches;

	uart_line_coding_baud_divider dut (.*);

	uart_line_coding_baud_divider_check checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#80000000;
		$display("uart_line_coding_baud_divider_test: FAIL");
		$finish;
	end

	// idle length: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(15, 4);
		return $urandom_range(120, 30);
	endfunction

	// offer one item at the current falling edge and hold it until taken
	task automatic send_req(input logic [31:0] b, input logic [7:0] d, input logic [7:0] p,
			input logic [7:0] s, input bit paced);
		int unsigned gap;
		in_valid <= 1'b1;
		req_baud <= b;
		req_data_bits <= d;
		req_parity <= p;
		req_stop_bits <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		gap = paced ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// random coding, biased toward the fractional search region for this clock
	task automatic send_random(input logic [26:0] hz, input bit paced);
		logic [31:0]     b;
		logic [7:0]      d, p, s;
		longint unsigned c, lo, hi;
		c = hz / 16;
		lo = c / 30 + 1;
		hi = c + c / 4;
		if (lo < ulcbd_pkg::BaudMin)
			lo = ulcbd_pkg::BaudMin;
		if (hi > ulcbd_pkg::BaudMax)
			hi = ulcbd_pkg::BaudMax;
		case ($urandom_range(15, 0))
			0, 1: b = $urandom;
			2: begin
				case ($urandom_range(5, 0))
					0: b = 32'd0;
					1: b = ulcbd_pkg::BaudMin - 32'd1;
					2: b = ulcbd_pkg::BaudMin;
					3: b = ulcbd_pkg::BaudMax;
					4: b = ulcbd_pkg::BaudMax + 32'd1;
					default: b = 32'hFFFF_FFFF;
				endcase
			end
			3, 4, 5, 6: b = (lo <= hi) ? $urandom_range(32'(hi), 32'(lo)) :
				$urandom_range(ulcbd_pkg::BaudMax, ulcbd_pkg::BaudMin);
			7, 8, 9, 10: begin
				b = $urandom_range(ulcbd_pkg::BaudMax, ulcbd_pkg::BaudMin) >>
					$urandom_range(16, 0);
				if (b < ulcbd_pkg::BaudMin)
					b = ulcbd_pkg::BaudMin;
			end
			default: b = $urandom_range(ulcbd_pkg::BaudMax, ulcbd_pkg::BaudMin);
		endcase
		d = 8'(($urandom_range(9, 0) < 8) ? $urandom_range(8, 5) : $urandom_range(255, 0));
		p = 8'(($urandom_range(9, 0) < 8) ? $urandom_range(4, 0) : $urandom_range(255, 0));
		if ($urandom_range(9, 0) < 7)
			s = $urandom_range(1, 0) ? STwo : SOne;
		else
			s = 8'($urandom_range(255, 0));
		send_req(b, d, p, s, paced);
	endtask

	task automatic wait_drained(input int unsigned settle);
		while (open_items != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// result side: open windows and stalls, plus long hold-offs to back up the input
	initial begin : result_side
		int unsigned run, gap, cyc, hold_at;
		bit          held_once;
		out_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		cyc = 0;
		held_once = 1'b0;
		hold_at = $urandom_range(12000, 3000);
		forever begin
			out_stall <= 1'b0;
			run = ($urandom_range(3, 0) == 0) ? $urandom_range(600, 200) : $urandom_range(60, 1);
			repeat (run) @(negedge clk);
			cyc += run;
			if (!held_once && cyc >= hold_at) begin
				gap = 1500;
				held_once = 1'b1;
			end else if ($urandom_range(299, 0) == 0) begin
				gap = $urandom_range(1000, 400);
			end else begin
				gap = pick_gap();
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				cyc += gap;
			end
		end
	end

	// stimulus: directed codings at reset clock, then random phases over clock settings
	initial begin : stimulus
		logic [26:0] hz;
		int unsigned ph, n;
		bit          paced;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		req_baud = '0;
		req_data_bits = '0;
		req_parity = '0;
		req_stop_bits = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: limits, fallbacks, odd parity codes, search boundary
		send_req(ulcbd_pkg::BaudMin, 8'd5, 8'd0, SOne, 1'b1);
		send_req(ulcbd_pkg::BaudMax, 8'd8, 8'd1, STwo, 1'b1);
		send_req(ulcbd_pkg::BaudMin - 32'd1, 8'd4, 8'd2, 8'd1, 1'b1);
		send_req(ulcbd_pkg::BaudMax + 32'd1, 8'd9, 8'd3, 8'd3, 1'b1);
		send_req(32'd0, 8'd0, 8'd4, 8'd255, 1'b1);
		send_req(32'hFFFF_FFFF, 8'd255, 8'd255, SOne, 1'b1);
		send_req(32'd9600, 8'd6, 8'd5, STwo, 1'b1);
		send_req(32'd115200, 8'd7, 8'd0, SOne, 1'b1);
		send_req(32'd2999999, 8'd8, 8'd128, STwo, 1'b1);
		send_req(32'h8000_0000, 8'd5, 8'd1, 8'h80, 1'b1);
		send_req(32'd1200, 8'd8, 8'd2, SOne, 1'b1);
		send_req(32'd1000000, 8'd8, 8'd0, STwo, 1'b1);
		send_req(32'd250000, 8'd8, 8'd0, SOne, 1'b1);
		send_req(32'd100000, 8'd5, 8'd4, SOne, 1'b1);
		send_req(32'd103448, 8'd6, 8'd3, STwo, 1'b1);
		send_req(32'd46, 8'd7, 8'd254, SOne, 1'b0);
		send_req(32'd3000000, 8'd8, 8'd0, SOne, 1'b0);

		for (ph = 0; ph < NumPhases; ph++) begin
			in_valid <= 1'b0;
			wait_drained(8);
			case (ph)
				0: hz = 27'd1000000;
				1: hz = 27'd100000000;
				2: hz = 27'd0;
				3: hz = 27'h7FF_FFFF;
				4: hz = 27'd16;
				5: hz = 27'($urandom_range(100000000, 1000000));
				6: hz = 27'($urandom_range(32'h7FF_FFFF, 0));
				7: hz = 27'($urandom_range(999999, 17));
				8: hz = 27'($urandom_range(100000000, 1000000));
				default: hz = ulcbd_pkg::ClkReset;
			endcase
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= hz;
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			cfg_wr_data <= 27'($urandom);
			@(negedge clk);
			paced = ($urandom_range(3, 0) != 0);
			send_req(ulcbd_pkg::BaudMin, 8'd8, 8'd0, SOne, paced);
			send_req(ulcbd_pkg::BaudMax, 8'd5, 8'd2, STwo, paced);
			for (n = 0; n < ItemsPerPhase; n++)
				send_random(hz, paced);
		end
		in_valid <= 1'b0;
		wait_drained(350);

		if (mismatches == 0 && open_items == 0)
			$display("uart_line_coding_baud_divider_test: PASS");
		else
			$display("uart_line_coding_baud_divider_test: FAIL");
		$finish;
	end

endmodule

// File: uart_line_coding_baud_divider.f
+incdir+design
design/ulcbd_pkg.sv
design/ulcbd_div.sv
design/uart_line_coding_baud_divider.sv
tb/uart_line_coding_baud_divider_check.sv
tb/uart_line_coding_baud_divider_test.sv
